// ===== rtl/sita_pkg.sv =====
// ----------------------------------------------------------------------------
// sita_pkg
// shared types, constants and helpers for the signed integer to ascii block
// ----------------------------------------------------------------------------
package sita_pkg;

   localparam int unsigned DEFAULT_VALUE_WIDTH = 32;
   localparam int unsigned RADIX_WIDTH         = 4;
   localparam int unsigned DIGIT_WIDTH         = 4;
   localparam int unsigned CHAR_WIDTH          = 7;

   localparam logic [RADIX_WIDTH-1:0] RADIX_RESET = 4'd10;
   localparam logic [RADIX_WIDTH-1:0] RADIX_MIN   = 4'd2;
   localparam logic [RADIX_WIDTH-1:0] RADIX_MAX   = 4'd10;

   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 7'd48;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 7'd45;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_PUSH,
      ST_SIGN,
      ST_EMIT
   } sita_state_type;

   // clamp the programmed radix into the supported range
   function automatic logic [RADIX_WIDTH-1:0] effective_radix(
      input logic [RADIX_WIDTH-1:0] radix
   );
      logic [RADIX_WIDTH-1:0] base;
      base = radix;
      if (radix < RADIX_MIN) begin
         base = RADIX_MIN;
      end else if (radix > RADIX_MAX) begin
         base = RADIX_MAX;
      end
      return base;
   endfunction

endpackage

// ===== rtl/sita_req_if.sv =====
// ----------------------------------------------------------------------------
// sita_req_if
// input channel: one signed value per item
// ----------------------------------------------------------------------------
interface sita_req_if
   import sita_pkg::*;
#(
   parameter int unsigned VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) ();

   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] number;

   modport source (output valid, output number, input ready);
   modport sink (input valid, input number, output ready);

endinterface

// ===== rtl/sita_rsp_if.sv =====
// ----------------------------------------------------------------------------
// sita_rsp_if
// result channel: one ascii character per item
// ----------------------------------------------------------------------------
interface sita_rsp_if
   import sita_pkg::*;
();

   logic                  valid;
   logic                  ready;
   logic [CHAR_WIDTH-1:0] character;
   logic                  last_char;

   modport source (output valid, output character, output last_char, input ready);
   modport sink (input valid, input character, input last_char, output ready);

endinterface

// ===== rtl/signed_integer_to_ascii.sv =====
// ----------------------------------------------------------------------------
// signed_integer_to_ascii
// converts a signed integer to its ascii text in a programmable radix
// ----------------------------------------------------------------------------
//
//   channel    direction  payload                      handshake
//   req_chan   in         number [VALUE_WIDTH]         valid / ready
//   rsp_chan   out        character [7], last_char     valid / ready
//   csr_*      in         radix [4]                    write enable only
//
// one item is taken only while idle. each digit is formed on the shared
// bit-serial divider (one quotient bit per cycle, then a push); once all digits
// are on the stack, the characters follow, one per cycle while rsp_chan is
// not stalled. reset (synchronous) returns to idle and sets the radix to ten.
// a stalled result simply holds; the sequencer waits in its sign or emit state.
//
module signed_integer_to_ascii
   import sita_pkg::*;
#(
   parameter int unsigned VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [RADIX_WIDTH-1:0] csr_write_data,
   sita_req_if.sink               req_chan,
   sita_rsp_if.source             rsp_chan
);

   localparam int unsigned BIT_CNT_WIDTH   = $clog2(VALUE_WIDTH);
   localparam int unsigned DIGIT_CNT_WIDTH = $clog2(VALUE_WIDTH + 1);
   localparam int unsigned STACK_WIDTH     = DIGIT_WIDTH * VALUE_WIDTH;
   localparam logic [BIT_CNT_WIDTH-1:0] BIT_LAST = BIT_CNT_WIDTH'(VALUE_WIDTH - 1);
   localparam logic [DIGIT_CNT_WIDTH-1:0] ONE_DIGIT = DIGIT_CNT_WIDTH'(1);

   // control registers
   sita_state_type               state_ff, state_in;
   logic [RADIX_WIDTH-1:0]       radix_ff;

   // datapath registers
   logic [VALUE_WIDTH-1:0]       quo_ff, quo_in;       // dividend, becomes quotient
   logic [DIGIT_WIDTH-1:0]       rem_ff, rem_in;       // partial remainder
   logic [RADIX_WIDTH-1:0]       base_ff, base_in;     // radix latched per item
   logic                         neg_ff, neg_in;
   logic [BIT_CNT_WIDTH-1:0]     bit_cnt_ff, bit_cnt_in;
   logic [DIGIT_CNT_WIDTH-1:0]   dig_cnt_ff, dig_cnt_in;
   logic [STACK_WIDTH-1:0]       stack_ff, stack_in;   // digit stack, top at low end

   // shared divider step
   logic [DIGIT_WIDTH:0]         trial;
   logic                         trial_ge;
   logic [DIGIT_WIDTH:0]         trial_diff;
   logic [VALUE_WIDTH-1:0]       magnitude;

   assign trial      = {rem_ff, quo_ff[VALUE_WIDTH-1]};
   assign trial_ge   = (trial >= {1'b0, base_ff});
   assign trial_diff = trial - {1'b0, base_ff};

   // unsigned magnitude, so the most negative value needs no special case
   assign magnitude = req_chan.number[VALUE_WIDTH-1]
                    ? ({VALUE_WIDTH{1'b0}} - $unsigned(req_chan.number))
                    : $unsigned(req_chan.number);

   // handshake outputs
   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign rsp_chan.valid     = (state_ff == ST_SIGN) || (state_ff == ST_EMIT);
   assign rsp_chan.character = (state_ff == ST_SIGN)
                             ? CHAR_MINUS
                             : CHAR_ZERO + {{(CHAR_WIDTH - DIGIT_WIDTH){1'b0}},
                                            stack_ff[DIGIT_WIDTH-1:0]};
   assign rsp_chan.last_char = (state_ff == ST_EMIT) && (dig_cnt_ff == ONE_DIGIT);

   // sequencer
   always_comb begin
      state_in   = state_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      base_in    = base_ff;
      neg_in     = neg_ff;
      bit_cnt_in = bit_cnt_ff;
      dig_cnt_in = dig_cnt_ff;
      stack_in   = stack_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               quo_in     = magnitude;
               rem_in     = '0;
               neg_in     = req_chan.number[VALUE_WIDTH-1];
               base_in    = effective_radix(radix_ff);
               bit_cnt_in = '0;
               dig_cnt_in = '0;
               state_in   = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            // one restoring division step, quotient bit shifts in at the bottom
            rem_in     = trial_ge ? trial_diff[DIGIT_WIDTH-1:0] : trial[DIGIT_WIDTH-1:0];
            quo_in     = {quo_ff[VALUE_WIDTH-2:0], trial_ge};
            bit_cnt_in = bit_cnt_ff + 1'b1;
            if (bit_cnt_ff == BIT_LAST) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            // remainder is the next digit, least significant first
            stack_in   = {stack_ff[STACK_WIDTH-DIGIT_WIDTH-1:0], rem_ff};
            dig_cnt_in = dig_cnt_ff + 1'b1;
            rem_in     = '0;
            bit_cnt_in = '0;
            if (quo_ff == '0) begin
               state_in = neg_ff ? ST_SIGN : ST_EMIT;
            end else begin
               state_in = ST_DIVIDE;
            end
         end
         ST_SIGN: begin
            if (rsp_chan.ready) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // pop most significant digit first
            if (rsp_chan.ready) begin
               stack_in   = stack_ff >> DIGIT_WIDTH;
               dig_cnt_in = dig_cnt_ff - 1'b1;
               if (dig_cnt_ff == ONE_DIGIT) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // radix register
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
      end else if (csr_write_enable) begin
         radix_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      base_ff    <= base_in;
      neg_ff     <= neg_in;
      bit_cnt_ff <= bit_cnt_in;
      dig_cnt_ff <= dig_cnt_in;
      stack_ff   <= stack_in;
   end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for signed_integer_to_ascii: every value taken is
// turned into its expected text by a behavioral predictor, and each character
// that comes back is matched against the oldest pending one, under random
// idling on both channels, a long result stall and a sweep of radix settings
// ----------------------------------------------------------------------------
module tb_top
   import sita_pkg::*;
();

   localparam int unsigned VW             = DEFAULT_VALUE_WIDTH;
   localparam int unsigned WATCHDOG_LIMIT = 20000;  // quiet cycles before giving up
   localparam int unsigned HOLD_CYCLES    = 400;    // long result stall
   localparam int unsigned HOLD_AT_ITEM   = 40;     // start the stall at this item
   localparam int unsigned RANDOM_PHASES  = 10;
   localparam int unsigned PHASE_ITEMS    = 10;
   localparam int unsigned CALM_PHASE     = 4;      // phase run with no idling at all
   localparam int unsigned SETTLE_CYCLES  = 100;

   // one expected character of the text
   typedef struct packed {
      logic [CHAR_WIDTH-1:0] character;
      logic                  last_char;
   } ascii_char_type;

   // ------------------------------------------------------------------------
   // expected text store and predictor
   // ------------------------------------------------------------------------
   class text_scoreboard;
      ascii_char_type         expected_text[$];
      logic [RADIX_WIDTH-1:0] radix_reg;
      int unsigned            numbers_taken;
      int unsigned            mismatches;

      function new();
         radix_reg     = RADIX_RESET;
         numbers_taken = 0;
         mismatches    = 0;
      endfunction

      function void write_radix(input logic [RADIX_WIDTH-1:0] value);
         radix_reg = value;
      endfunction

      function int unsigned pending();
         return expected_text.size();
      endfunction

      // turn one accepted value into its characters, sign first
      function void note_number(input logic [VW-1:0] number);
         logic [VW-1:0]  magnitude;
         logic [VW-1:0]  base;
         ascii_char_type digits[$];
         ascii_char_type one;
         numbers_taken++;
         // radix values outside two to ten are pulled to the nearest end
         if (radix_reg < RADIX_MIN) begin
            base = VW'(RADIX_MIN);
         end else if (radix_reg > RADIX_MAX) begin
            base = VW'(RADIX_MAX);
         end else begin
            base = VW'(radix_reg);
         end
         // unsigned magnitude, so the most negative value survives
         magnitude = number[VW-1] ? (~number + 1'b1) : number;
         if (number[VW-1]) begin
            one.character = CHAR_MINUS;
            one.last_char = 1'b0;
            expected_text.push_back(one);
         end
         do begin
            one.character = CHAR_ZERO + CHAR_WIDTH'(magnitude % base);
            one.last_char = 1'b0;
            digits.push_front(one);
            magnitude = magnitude / base;
         end while (magnitude != 0);
         digits[digits.size()-1].last_char = 1'b1;
         foreach (digits[i]) expected_text.push_back(digits[i]);
      endfunction

      function void check_char(input logic [CHAR_WIDTH-1:0] character,
                               input logic last_char);
         ascii_char_type want;
         if (expected_text.size() == 0) begin
            $error("unexpected item: character %0d, last_char %0b", character, last_char);
            mismatches++;
            return;
         end
         want = expected_text.pop_front();
         if (want.character !== character) begin
            $error("character mismatch: expected %0d, actual %0d",
                   want.character, character);
            mismatches++;
         end
         if (want.last_char !== last_char) begin
            $error("last_char mismatch: expected %0b, actual %0b",
                   want.last_char, last_char);
            mismatches++;
         end
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // clock, reset, channels and the block
   // ------------------------------------------------------------------------
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_write_enable = 1'b0;
   logic [RADIX_WIDTH-1:0] csr_write_data = '0;
   bit                     calm = 1'b0;   // set while no side may idle

   sita_req_if #(.VALUE_WIDTH(VW)) req_if ();
   sita_rsp_if                     rsp_if ();

   text_scoreboard sb = new();

   signed_integer_to_ascii #(.VALUE_WIDTH(VW)) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // idle with a chance of roughly 28 in a hundred, none while calm
   function automatic bit take_break();
      return !calm && ($urandom_range(0, 99) < 28);
   endfunction

   // ------------------------------------------------------------------------
   // input side
   // ------------------------------------------------------------------------

   // offer one value, after a random gap, and hold it until it is taken
   task automatic send_number(input logic [VW-1:0] number);
      @(negedge clock);
      while (take_break()) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.number <= number;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.note_number(number);
   endtask

   // stop offering and wait for every pending character; the block is back
   // in idle in the cycle after its last character is taken
   task automatic wait_idle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // radix write, only ever issued with the block idle
   task automatic program_radix(input logic [RADIX_WIDTH-1:0] value);
      wait_idle();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      sb.write_radix(value);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // random value shaped to hit short texts, digit-count boundaries and extremes
   function automatic logic [VW-1:0] pick_number(input logic [RADIX_WIDTH-1:0] radix_value);
      longint        power;
      int unsigned   base;
      int unsigned   steps;
      logic [VW-1:0] value;
      base = (radix_value < 2) ? 2 : (radix_value > 10) ? 10 : radix_value;
      case ($urandom_range(0, 5))
         0, 1: begin
            value = $urandom;
         end
         2: begin
            value = $urandom_range(0, 40) - 20;
         end
         3: begin
            // a power of the base, or one below it, either sign
            power = 1;
            steps = $urandom_range(1, 31);
            while (steps > 0 && power * base <= 64'sd2147483648) begin
               power = power * base;
               steps--;
            end
            value = VW'(power - $urandom_range(0, 1));
            if ($urandom_range(0, 1)) value = -value;
         end
         4: begin
            case ($urandom_range(0, 3))
               0: value = {1'b1, {(VW-1){1'b0}}};
               1: value = {1'b0, {(VW-1){1'b1}}};
               2: value = '0;
               default: value = '1;
            endcase
         end
         default: begin
            value = $urandom_range(0, 99999);
            if ($urandom_range(0, 1)) value = -value;
         end
      endcase
      return value;
   endfunction

   // ------------------------------------------------------------------------
   // result side: random stalls, plus one long hold while items keep coming
   // ------------------------------------------------------------------------
   initial begin : result_sink
      int unsigned hold_left;
      bit          held;
      hold_left    = 0;
      held         = 1'b0;
      rsp_if.ready = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (!held && sb.numbers_taken >= HOLD_AT_ITEM) begin
            held      = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= !take_break();
         end
         @(posedge clock);
         if (rsp_if.valid && rsp_if.ready) begin
            sb.check_char(rsp_if.character, rsp_if.last_char);
         end
      end
   end

   // ------------------------------------------------------------------------
   // watchdog: too long with no item moving on either channel
   // ------------------------------------------------------------------------
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("tb_top: FAIL");
      $finish;
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   initial begin : stimulus
      logic [RADIX_WIDTH-1:0] radix_value;
      req_if.valid  = 1'b0;
      req_if.number = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // decimal: zero, unit values, both extremes, digit-count edges
      program_radix(4'd10);
      send_number('0);
      send_number(32'sd1);
      send_number(-32'sd1);
      send_number(32'h7FFF_FFFF);
      send_number(32'h8000_0000);
      send_number(32'sd9);
      send_number(32'sd10);
      send_number(-32'sd10);

      // binary: longest text is the most negative value
      program_radix(4'd2);
      send_number('0);
      send_number(32'h8000_0000);
      send_number(32'h7FFF_FFFF);
      send_number(32'sd5);

      // radix below two behaves as binary
      program_radix(4'd0);
      send_number(-32'sd1);
      send_number(32'sd6);
      program_radix(4'd1);
      send_number(32'sd3);

      // radix above ten behaves as decimal
      program_radix(4'd15);
      send_number(-32'sd123456789);
      program_radix(4'd11);
      send_number(32'sd100);

      program_radix(4'd3);
      send_number(32'sd8);
      send_number(32'sd9);
      program_radix(4'd9);
      send_number(-32'sd80);

      // random phases, each under a fresh radix setting
      for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
         radix_value = $urandom_range(0, 15);
         program_radix(radix_value);
         calm = (phase == CALM_PHASE);
         for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
            send_number(pick_number(radix_value));
         end
      end
      calm = 1'b0;

      // drain, then give any stray character time to show up
      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
